/* rtl/cpu16_instruction_execute_defines.svh */
// Assertion macros shared by the instruction execute block.
`ifndef CPU16_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CPU16_INSTRUCTION_EXECUTE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property at every rising edge outside reset.
`define C16IE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("c16ie assertion failed");
// Check a property at every rising edge, reset included.
`define C16IE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("c16ie assertion failed");
`else
`define C16IE_ASSERT(lbl, clk, rst, prop)
`define C16IE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/c16ie_pkg.sv */
// Types and constants shared by the instruction execute block.
package c16ie_pkg;

  localparam int unsigned XLEN      = 16;
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned SYS_CODE_W = 3;
  localparam int unsigned OUT_BYTES_W = 80;

  localparam logic [REG_IDX_W-1:0] PC_INDEX   = 4'hF;
  localparam logic [REG_IDX_W-1:0] SYS_TARGET = 4'hF;

  typedef enum logic [3:0] {
    OP_MOVE  = 4'h0,
    OP_ADD   = 4'h1,
    OP_SUB   = 4'h2,
    OP_AND   = 4'h3,
    OP_OR    = 4'h4,
    OP_XOR   = 4'h5,
    OP_SHIFT = 4'h6,
    OP_MUL   = 4'h7,
    OP_STORE = 4'h8,
    OP_LDI   = 4'h9,
    OP_GTU   = 4'hA,
    OP_GTS   = 4'hB,
    OP_LTU   = 4'hC,
    OP_LTS   = 4'hD,
    OP_EQ    = 4'hE,
    OP_JUMP  = 4'hF
  } op_t;

  typedef enum logic [1:0] {
    SH_ASR = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_LSL = 2'd3
  } shift_kind_t;

  typedef struct packed {
    logic [XLEN-1:0]       next_pc;
    logic                  wb_enable;
    logic [REG_IDX_W-1:0]  wb_index;
    logic [XLEN-1:0]       wb_value;
    logic                  mem_write;
    logic [XLEN-1:0]       mem_addr;
    logic [XLEN-1:0]       mem_data;
    logic                  syscall_request;
    logic [SYS_CODE_W-1:0] syscall_code;
  } result_t;

endpackage

/* rtl/c16ie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c16ie_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/c16ie_alu.sv */
// Execute logic: operation decode, ALU, PC and system call resolution.
module c16ie_alu import c16ie_pkg::*; (
  input  logic [XLEN-1:0]       instr,
  input  logic [XLEN-1:0]       a,
  input  logic [XLEN-1:0]       b,
  input  logic [XLEN-1:0]       pc_inc,
  input  logic [SYS_CODE_W-1:0] reg0_code,
  output result_t               res
);

  op_t                  op;
  logic [REG_IDX_W-1:0] dest;
  logic [REG_IDX_W-1:0] target;
  logic [3:0]           sh_amt;
  shift_kind_t          sh_kind;
  logic [2*XLEN-1:0]    prod;
  logic [2*XLEN-1:0]    rot_wide;
  logic [XLEN-1:0]      sh_val;
  logic [XLEN-1:0]      value;

  assign op      = op_t'(instr[15:12]);
  assign dest    = instr[11:8];
  assign target  = instr[3:0];
  assign sh_amt  = b[3:0];
  assign sh_kind = shift_kind_t'(b[5:4]);
  assign prod    = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
  assign rot_wide = {a, a} << sh_amt;

  always_comb begin
    case (sh_kind)
      SH_ASR:  sh_val = XLEN'($signed(a) >>> sh_amt);
      SH_LSR:  sh_val = a >> sh_amt;
      SH_ROL:  sh_val = rot_wide[2*XLEN-1:XLEN];
      default: sh_val = a << sh_amt;
    endcase
  end

  // Signed compares of this block: when the sign bits differ, the negative operand
  // decides (greater-than gives 1 for a negative A, less-than for a negative B).
  always_comb begin
    unique case (op)
      OP_MOVE:  value = b;
      OP_ADD:   value = a + b;
      OP_SUB:   value = a - b;
      OP_AND:   value = a & b;
      OP_OR:    value = a | b;
      OP_XOR:   value = a ^ b;
      OP_SHIFT: value = sh_val;
      OP_MUL:   value = prod[XLEN-1:0];
      OP_STORE: value = a;
      OP_LDI:   value = {8'h00, instr[7:0]};
      OP_GTU:   value = XLEN'(a > b);
      OP_GTS:   value = XLEN'((a[XLEN-1] != b[XLEN-1]) ? a[XLEN-1] : (a > b));
      OP_LTU:   value = XLEN'(a < b);
      OP_LTS:   value = XLEN'((a[XLEN-1] != b[XLEN-1]) ? b[XLEN-1] : (a < b));
      OP_EQ:    value = XLEN'(a == b);
      OP_JUMP:  value = (dest == PC_INDEX) ? {12'h000, target} : pc_inc;
    endcase
  end

  always_comb begin
    res.wb_enable = 1'b1;
    res.wb_index  = dest;
    res.wb_value  = value;
    res.next_pc   = (dest == PC_INDEX) ? value : pc_inc;
    res.mem_write = (op == OP_STORE);
    res.mem_addr  = (op == OP_STORE) ? b : '0;
    res.mem_data  = (op == OP_STORE) ? a : '0;
    res.syscall_request = (op == OP_JUMP) && (target == SYS_TARGET);
    // Code comes from register 0 after the jump's own link write.
    if (res.syscall_request) begin
      res.syscall_code = (dest == '0) ? pc_inc[SYS_CODE_W-1:0] : reg0_code;
    end else begin
      res.syscall_code = '0;
    end
  end

endmodule

/* rtl/cpu16_instruction_execute.sv */
// Top level of the 16-bit instruction execute block.
//
// Takes one instruction word per item on the s_ side and returns one result item per
// instruction on the m_ side, in order. Sustained rate is one instruction per clock;
// an accepted item is registered into the execute stage along with its register file
// read, then executed into the output register. The sixteen general registers sit
// in two copies of a 16 x 16 synchronous RAM, one per source operand port, written
// together; the PC (register 15) and a copy of register 0 are kept in flip-flops so a
// read of register 15 always returns the incremented PC and a system call can take its
// code from register 0. The most recent write is held and forwarded to the next
// instruction, so dependent instructions issue back to back without an interlock.
// Per-entry valid bits make never-written registers read as zero after reset, with no
// clearing pass. A result waiting on m_tready holds the execute stage, and that in turn
// drops s_tready; otherwise a new item is taken every cycle.
`include "cpu16_instruction_execute_defines.svh"
module cpu16_instruction_execute import c16ie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // instr[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_pc[15:0], wb_enable[16], wb_index[20:17], wb_value[36:21], mem_write[37],
  // mem_addr[53:38], mem_data[69:54], syscall_request[70], syscall_code[73:71],
  // zero fill [79:74]
  output logic [79:0] m_tdata
);

  // Issue and execute stage control
  logic                 s_accept;
  logic                 advance;
  logic                 s1_valid;
  logic [XLEN-1:0]      s1_instr;

  // Architectural state outside the RAM
  logic [XLEN-1:0]      pc;
  logic [XLEN-1:0]      pc_inc;
  logic [XLEN-1:0]      reg0;
  logic [NUM_REGS-1:0]  reg_valid;

  // Last write, forwarded over the RAM read latency
  logic                 lw_valid;
  logic [REG_IDX_W-1:0] lw_index;
  logic [XLEN-1:0]      lw_value;

  logic [XLEN-1:0]      rdata_a;
  logic [XLEN-1:0]      rdata_b;
  logic [REG_IDX_W-1:0] src_a;
  logic [REG_IDX_W-1:0] src_b;
  logic [XLEN-1:0]      opnd_a;
  logic [XLEN-1:0]      opnd_b;

  result_t              res;
  result_t              out_res;
  logic                 out_valid;

  // Advance the execute stage whenever the output register is free or draining.
  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  c16ie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_ram_a (
    .clk   (clk),
    .we    (advance),
    .waddr (res.wb_index),
    .wdata (res.wb_value),
    .re    (s_accept),
    .raddr (s_tdata[7:4]),
    .rdata (rdata_a)
  );

  c16ie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_ram_b (
    .clk   (clk),
    .we    (advance),
    .waddr (res.wb_index),
    .wdata (res.wb_value),
    .re    (s_accept),
    .raddr (s_tdata[3:0]),
    .rdata (rdata_b)
  );

  assign pc_inc = pc + 16'd1;
  assign src_a  = s1_instr[7:4];
  assign src_b  = s1_instr[3:0];

  // Pick the PC for register 15, then the forwarded write, then RAM data, which is
  // only trusted once that entry has been written.
  always_comb begin
    if (src_a == PC_INDEX) begin
      opnd_a = pc_inc;
    end else if (lw_valid && (lw_index == src_a)) begin
      opnd_a = lw_value;
    end else if (reg_valid[src_a]) begin
      opnd_a = rdata_a;
    end else begin
      opnd_a = '0;
    end
    if (src_b == PC_INDEX) begin
      opnd_b = pc_inc;
    end else if (lw_valid && (lw_index == src_b)) begin
      opnd_b = lw_value;
    end else if (reg_valid[src_b]) begin
      opnd_b = rdata_b;
    end else begin
      opnd_b = '0;
    end
  end

  c16ie_alu u_alu (
    .instr     (s1_instr),
    .a         (opnd_a),
    .b         (opnd_b),
    .pc_inc    (pc_inc),
    .reg0_code (reg0[SYS_CODE_W-1:0]),
    .res       (res)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      reg0      <= '0;
      reg_valid <= '0;
      lw_valid  <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        pc                      <= res.next_pc;
        reg_valid[res.wb_index] <= 1'b1;
        lw_valid                <= 1'b1;
        if (res.wb_index == '0) begin
          reg0 <= res.wb_value;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_instr <= s_tdata;
    end
    if (advance) begin
      out_res  <= res;
      lw_index <= res.wb_index;
      lw_value <= res.wb_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000,
                     out_res.syscall_code,
                     out_res.syscall_request,
                     out_res.mem_data,
                     out_res.mem_addr,
                     out_res.mem_write,
                     out_res.wb_value,
                     out_res.wb_index,
                     out_res.wb_enable,
                     out_res.next_pc};

  // Input is held off only by a result waiting behind a stalled output.
  `C16IE_ASSERT(a_ready_only_on_stall, clk, rst, !s_tready |-> (s1_valid && out_valid && !m_tready))
  // A stalled execute stage keeps its instruction.
  `C16IE_ASSERT(a_stage_holds, clk, rst, (s1_valid && !advance) |=> (s1_valid && $stable(s1_instr)))
  // A write to register 15 is the next PC.
  `C16IE_ASSERT(a_pc_dest, clk, rst, (out_valid && out_res.wb_index == PC_INDEX) |-> (out_res.next_pc == out_res.wb_value))
  // Non-store results carry a zero address and data.
  `C16IE_ASSERT(a_nostore_zero, clk, rst, (out_valid && !out_res.mem_write) |-> (out_res.mem_addr == '0 && out_res.mem_data == '0))
  // The PC only moves when an instruction completes execute.
  `C16IE_ASSERT(a_pc_moves_on_advance, clk, rst, (!rst && !advance) |=> $stable(pc))

endmodule
